// ===== rtl/tmc_pkg.sv =====
// shared types, constants and helpers for the matrix compose block
package tmc_pkg;

  localparam int PosW     = 32;
  localparam int QuatW    = 16;
  localparam int ScaleW   = 24;
  localparam int ProdQW   = 2 * QuatW;
  localparam int RmW      = ProdQW + 1;
  localparam int ColW     = 32;
  localparam int MulW     = 2 * RmW;
  localparam int NumW     = 68;
  localparam int DenW     = 34;
  localparam int QuoW     = 32;
  localparam int StepW    = $clog2(QuoW);
  localparam int RowW     = 2;
  localparam int InDataW  = 232;
  localparam int OutDataW = 136;
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [RowW-1:0] LastRow = 2'd2;
  localparam logic signed [RmW-1:0] OneQ27 = 33'sd134217728;
  localparam logic [ColW-1:0] ColMax = 32'h7fff_ffff;
  localparam logic [ColW-1:0] ColMin = 32'h8000_0000;

  // rotation, position and scale of one item, ready for the row engine
  typedef struct packed {
    logic                              inv;
    logic [2:0][2:0][RmW-1:0]          rm;
    logic [2:0][PosW-1:0]              pos;
    logic [2:0][ScaleW-1:0]            scale;
  } xform_t;

  typedef struct packed {
    logic                   load;
    logic [NumW-1:0]        num;
    logic [DenW-1:0]        den;
    logic                   zpos;
    logic                   zneg;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [ColW-1:0] res;
  } div_rsp_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic [ColW-1:0] sat_col(logic signed [NumW-1:0] v);
    logic signed [NumW-1:0] hi;
    logic signed [NumW-1:0] lo;
    hi = NumW'($signed(ColMax));
    lo = NumW'($signed(ColMin));
    if (v > hi) return ColMax;
    else if (v < lo) return ColMin;
    else return v[ColW-1:0];
  endfunction

endpackage

// ===== rtl/trs_matrix_compose.sv =====
// top level: affine matrix rows from position, quaternion and scale
// Each input beat carries a position (Q16.16), a quaternion (Q2.14, used
// as given, not normalized), a per-axis scale (unsigned Q8.16) and in tuser
// the action: 0 builds T*R*S, 1 builds its inverse S^-1*R^T*T(-p). Three
// result beats follow per item, rows 0, 1, 2, with tlast on row 2; every
// entry is Q16.16, rounded to nearest with ties up, and saturated. The
// tuser bit of a result marks an inverse item with a zero scale component.
// A forward item leaves one row per cycle while the output is not stalled,
// its first row valid after the front-end register, the queue, the multiply
// stage and the output register. An inverse row goes through the four
// bit-serial divider lanes, a load step plus one quotient bit per cycle for
// 32 bits, so the lanes set the pace of inverse items. A two-entry queue
// lets the front end keep taking items while rows are worked off.
module trs_matrix_compose (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, scale_x, scale_y,
  // scale_z from the lowest bit up
  input  logic [tmc_pkg::InDataW-1:0]   s_axis_tdata_i,
  // action
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // row_index, col0, col1, col2, col3, then zero fill
  output logic [tmc_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // last_row
  output logic                          m_axis_tlast_o,
  // zero_scale
  output logic                          m_axis_tuser_o
);
  import tmc_pkg::*;

  // front end to queue
  logic   fr_valid, fr_ready;
  xform_t fr_xform;

  // queue to row engine
  logic   q_valid, q_pop;
  xform_t q_xform;

  logic [RowW-1:0]      row;
  logic [3:0][ColW-1:0] cols;

  tmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_action_i (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_xform_o (fr_xform)
  );

  tmc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_xform),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_xform)
  );

  tmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .xf_valid_i  (q_valid),
    .xf_i        (q_xform),
    .xf_pop_o    (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_row_o   (row),
    .out_cols_o  (cols),
    .out_last_o  (m_axis_tlast_o),
    .out_zero_o  (m_axis_tuser_o)
  );

  // pack the result beat, row index in the lowest bits
  assign m_axis_tdata_o = {6'b0, cols[3], cols[2], cols[1], cols[0], row};

endmodule

// ===== rtl/tmc_front.sv =====
// front end: takes an item, forms the quaternion products and the rotation
module tmc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   in_action_i,
  input  logic [tmc_pkg::InDataW-1:0] in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tmc_pkg::xform_t        out_xform_o
);
  import tmc_pkg::*;

  logic signed [QuatW-1:0] qx, qy, qz, qw;
  logic vld_q;
  logic inv_q;
  logic [2:0][PosW-1:0]   pos_q;
  logic [2:0][ScaleW-1:0] scale_q;
  logic signed [ProdQW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [RmW-1:0] exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;

  assign qx = $signed(in_data_i[111:96]);
  assign qy = $signed(in_data_i[127:112]);
  assign qz = $signed(in_data_i[143:128]);
  assign qw = $signed(in_data_i[159:144]);

  assign in_ready_o = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inv_q      <= in_action_i;
      pos_q[0]   <= in_data_i[31:0];
      pos_q[1]   <= in_data_i[63:32];
      pos_q[2]   <= in_data_i[95:64];
      scale_q[0] <= in_data_i[183:160];
      scale_q[1] <= in_data_i[207:184];
      scale_q[2] <= in_data_i[231:208];
      xx_q <= qx * qx;
      yy_q <= qy * qy;
      zz_q <= qz * qz;
      xy_q <= qx * qy;
      xz_q <= qx * qz;
      yz_q <= qy * qz;
      wx_q <= qw * qx;
      wy_q <= qw * qy;
      wz_q <= qw * qz;
    end
  end

  assign exx = RmW'(xx_q);
  assign eyy = RmW'(yy_q);
  assign ezz = RmW'(zz_q);
  assign exy = RmW'(xy_q);
  assign exz = RmW'(xz_q);
  assign eyz = RmW'(yz_q);
  assign ewx = RmW'(wx_q);
  assign ewy = RmW'(wy_q);
  assign ewz = RmW'(wz_q);

  always_comb begin
    out_xform_o.inv      = inv_q;
    out_xform_o.pos      = pos_q;
    out_xform_o.scale    = scale_q;
    out_xform_o.rm[0][0] = OneQ27 - (eyy + ezz);
    out_xform_o.rm[0][1] = exy - ewz;
    out_xform_o.rm[0][2] = exz + ewy;
    out_xform_o.rm[1][0] = exy + ewz;
    out_xform_o.rm[1][1] = OneQ27 - (exx + ezz);
    out_xform_o.rm[1][2] = eyz - ewx;
    out_xform_o.rm[2][0] = exz - ewy;
    out_xform_o.rm[2][1] = eyz + ewx;
    out_xform_o.rm[2][2] = OneQ27 - (exx + eyy);
  end

  assign out_valid_o = vld_q;

endmodule

// ===== rtl/tmc_fifo.sv =====
// short queue between the front end and the row engine
module tmc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  tmc_pkg::xform_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output tmc_pkg::xform_t pop_data_o
);
  import tmc_pkg::*;

  xform_t slot_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = cnt_q != FifoCntW'(FifoDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && pop_valid_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + FifoCntW'(push) - FifoCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== rtl/tmc_div.sv =====
// one bit per cycle floor divider lane with saturation to 32 bits
module tmc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tmc_pkg::div_req_t req_i,
  output tmc_pkg::div_rsp_t rsp_o
);
  import tmc_pkg::*;

  logic busy_q, done_q;
  logic [StepW-1:0] cnt_q;
  logic neg_q, ovf_q, zden_q, zpos_q, zneg_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [QuoW-1:0] low_q, quo_q;
  logic [NumW-1:0] mag;
  logic [DenW:0]   rem2;
  logic            ge;
  logic [QuoW:0]   qc;
  logic [QuoW-1:0] neg_res;

  assign mag  = req_i.num[NumW-1] ? (~req_i.num + 1'b1) : req_i.num;
  assign rem2 = {rem_q, low_q[QuoW-1]};
  assign ge   = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.load) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= StepW'(QuoW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      neg_q  <= req_i.num[NumW-1];
      ovf_q  <= mag >= NumW'({req_i.den, {QuoW{1'b0}}});
      zden_q <= req_i.den == '0;
      zpos_q <= req_i.zpos;
      zneg_q <= req_i.zneg;
      den_q  <= req_i.den;
      rem_q  <= mag[QuoW +: DenW];
      low_q  <= mag[QuoW-1:0];
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DenW'(rem2 - {1'b0, den_q}) : DenW'(rem2);
      low_q <= {low_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], ge};
    end
  end

  // negative quotient rounds away from zero before negation (floor)
  assign qc      = {1'b0, quo_q} + (QuoW+1)'(rem_q != '0);
  assign neg_res = ~qc[QuoW-1:0] + 1'b1;

  always_comb begin
    rsp_o.done = done_q;
    if (zden_q) begin
      rsp_o.res = zpos_q ? ColMax : (zneg_q ? ColMin : '0);
    end else if (neg_q) begin
      rsp_o.res = (ovf_q || qc > {2'b01, {(QuoW-1){1'b0}}}) ? ColMin : neg_res;
    end else begin
      rsp_o.res = (ovf_q || quo_q[QuoW-1]) ? ColMax : quo_q;
    end
  end

endmodule

// ===== rtl/tmc_back.sv =====
// row engine: multiplies, rounds or divides, and holds the result beat
module tmc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       xf_valid_i,
  input  tmc_pkg::xform_t            xf_i,
  output logic                       xf_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tmc_pkg::RowW-1:0]   out_row_o,
  output logic [3:0][tmc_pkg::ColW-1:0] out_cols_o,
  output logic                       out_last_o,
  output logic                       out_zero_o
);
  import tmc_pkg::*;

  logic [RowW-1:0] row_q;
  logic zflag;
  logic signed [RmW-1:0] op_a [3];
  logic signed [RmW-1:0] op_b [3];

  logic mv_q, m_inv_q, m_zero_q;
  logic [RowW-1:0] m_row_q;
  logic signed [MulW-1:0] m_prod_q [3];
  logic [RmW-1:0]    m_a_q [3];
  logic [ScaleW-1:0] m_s_q;
  logic [PosW-1:0]   m_pos_q;

  logic d_act_q, d_zero_q;
  logic [RowW-1:0] d_row_q;
  div_req_t req [4];
  div_rsp_t rsp [4];

  logic ov_q, o_last_q, o_zero_q;
  logic [RowW-1:0] o_row_q;
  logic [3:0][ColW-1:0] o_cols_q;

  logic out_free, div_fire, fwd_fire, load, m_adv, issue;
  logic signed [NumW-1:0] psum, tsum, shalf;
  logic [3:0][ColW-1:0] fwd_cols;

  assign zflag = xf_i.inv && (xf_i.scale[0] == '0 || xf_i.scale[1] == '0 ||
                              xf_i.scale[2] == '0);

  // inverse walks a column of the rotation against the position,
  // forward walks a row against the scales
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (xf_i.inv) begin
        op_a[j] = $signed(xf_i.rm[j][row_q]);
        op_b[j] = RmW'($signed(xf_i.pos[j]));
      end else begin
        op_a[j] = $signed(xf_i.rm[row_q][j]);
        op_b[j] = $signed({{(RmW-ScaleW){1'b0}}, xf_i.scale[j]});
      end
    end
  end

  assign out_free = !ov_q || out_ready_i;
  assign div_fire = d_act_q && rsp[0].done && out_free;
  assign fwd_fire = mv_q && !m_inv_q && !d_act_q && out_free;
  assign load     = mv_q && m_inv_q && (!d_act_q || div_fire);
  assign m_adv    = fwd_fire || load;
  assign issue    = xf_valid_i && (!mv_q || m_adv);
  assign xf_pop_o = issue && (row_q == LastRow);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      mv_q    <= 1'b0;
      d_act_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (issue) row_q <= (row_q == LastRow) ? '0 : row_q + 1'b1;
      if (issue) mv_q <= 1'b1;
      else if (m_adv) mv_q <= 1'b0;
      if (load) d_act_q <= 1'b1;
      else if (div_fire) d_act_q <= 1'b0;
      if (div_fire || fwd_fire) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      m_inv_q  <= xf_i.inv;
      m_zero_q <= zflag;
      m_row_q  <= row_q;
      m_s_q    <= xf_i.scale[row_q];
      m_pos_q  <= xf_i.pos[row_q];
      for (int j = 0; j < 3; j++) begin
        m_prod_q[j] <= op_a[j] * op_b[j];
        m_a_q[j]    <= op_a[j];
      end
    end
    if (load) begin
      d_row_q  <= m_row_q;
      d_zero_q <= m_zero_q;
    end
    if (div_fire) begin
      o_row_q  <= d_row_q;
      o_last_q <= d_row_q == LastRow;
      o_zero_q <= d_zero_q;
      for (int c = 0; c < 4; c++) o_cols_q[c] <= rsp[c].res;
    end else if (fwd_fire) begin
      o_row_q  <= m_row_q;
      o_last_q <= m_row_q == LastRow;
      o_zero_q <= m_zero_q;
      o_cols_q <= fwd_cols;
    end
  end

  // forward: round to nearest, ties up, then clamp
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      fwd_cols[j] = sat_col((NumW'(m_prod_q[j]) + NumW'(64'sd67108864)) >>> 27);
    end
    fwd_cols[3] = m_pos_q;
  end

  // inverse: numerators and denominators for the four lanes
  assign psum  = NumW'(m_prod_q[0]) + NumW'(m_prod_q[1]) + NumW'(m_prod_q[2]);
  assign tsum  = -psum;
  assign shalf = tsum >>> 1;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      req[j].load = load;
      req[j].num  = (NumW'($signed(m_a_q[j])) <<< 6) + NumW'(m_s_q);
      req[j].den  = DenW'({m_s_q, 1'b0});
      req[j].zpos = !m_a_q[j][RmW-1] && (m_a_q[j] != '0);
      req[j].zneg = m_a_q[j][RmW-1];
    end
    req[3].load = load;
    req[3].num  = shalf + NumW'({m_s_q, 9'b0});
    req[3].den  = {m_s_q, 10'b0};
    req[3].zpos = !tsum[NumW-1] && (tsum != '0);
    req[3].zneg = tsum[NumW-1];
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    tmc_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req[c]),
      .rsp_o  (rsp[c])
    );
  end

  assign out_valid_o = ov_q;
  assign out_row_o   = o_row_q;
  assign out_cols_o  = o_cols_q;
  assign out_last_o  = o_last_q;
  assign out_zero_o  = o_zero_q;

  a_last_matches_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (o_last_q == (o_row_q == LastRow)))
    else $error("last flag out of step with row");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (o_row_q <= LastRow))
    else $error("row index beyond last row");

  a_lanes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_act_q |-> (rsp[0].done == rsp[3].done) && (rsp[1].done == rsp[2].done))
    else $error("divider lanes out of step");

endmodule
